[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/lkv_pkg.sv]
`timescale 1ns / 1ps

package lkv_pkg;

	// Fixed port widths of the block.
	localparam int WORD_BITS  = 64;
	localparam int COUNT_BITS = 32;
	localparam int CMD_BITS   = 2;
	localparam int CAP_BITS   = 5;

	// Capacity register value after reset.
	localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

	// Operation codes carried in the command field.
	typedef enum logic [CMD_BITS-1:0] {
		CMD_GET    = 2'd0,
		CMD_PUT    = 2'd1,
		CMD_DELETE = 2'd2
	} command_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY,
		ST_INSERT,
		ST_FINISH
	} state_t;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic search;
		logic apply;
		logic insert;
		logic respond;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_insert;
		logic out_free;
	} dp_status_t;

endpackage

[src/lkv_ram.sv]
`timescale 1ns / 1ps

module lkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/lkv_ctrl.sv]
`timescale 1ns / 1ps

module lkv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lkv_pkg::dp_status_t  status,
	output lkv_pkg::dp_cmd_t     cmd
);

	import lkv_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath step commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = status.need_insert ? ST_INSERT : ST_FINISH;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/lkv_datapath.sv]
`timescale 1ns / 1ps

module lkv_datapath #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkv_pkg::dp_cmd_t                  cmd,
	output lkv_pkg::dp_status_t               status,
	input  logic                              cfg_write_en,
	input  logic [lkv_pkg::CAP_BITS-1:0]      cfg_write_data,
	input  logic [lkv_pkg::CMD_BITS-1:0]      command,
	input  logic [lkv_pkg::WORD_BITS-1:0]     key,
	input  logic [lkv_pkg::WORD_BITS-1:0]     value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [lkv_pkg::WORD_BITS-1:0]     read_value,
	output logic [lkv_pkg::COUNT_BITS-1:0]    hit_total,
	output logic [lkv_pkg::COUNT_BITS-1:0]    miss_total
);

	import lkv_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	// Item being worked on.
	logic [CMD_BITS-1:0]   cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// Entry table: keys, valid bits and recency ranks (0 is most recent).
	logic [KEY_BITS-1:0] entry_key_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  valid_d;
	logic [IDX_W-1:0]    rank_q [ENTRIES];
	logic [IDX_W-1:0]    rank_d [ENTRIES];
	logic [OCC_W-1:0]    occ_q;
	logic [OCC_W-1:0]    occ_d;

	logic [CAP_BITS-1:0]   capacity_q;
	logic [COUNT_BITS-1:0] hits_q;
	logic [COUNT_BITS-1:0] misses_q;

	// Search results.
	logic [ENTRIES-1:0] match_d;
	logic [ENTRIES-1:0] match_q;
	logic               found_q;

	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] sel_rank;
	logic [IDX_W-1:0] free_idx;
	logic [CMP_W-1:0] cap_wide;
	logic [OCC_W-1:0] cap_sat;
	logic [OCC_W-1:0] keep;

	logic                  is_get;
	logic                  is_put;
	logic                  is_delete;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic                  ram_re;
	logic [VALUE_BITS-1:0] ram_rdata;

	// Result register.
	logic                  out_valid_q;
	logic                  hit_q;
	logic [WORD_BITS-1:0]  read_value_q;
	logic [COUNT_BITS-1:0] hit_total_q;
	logic [COUNT_BITS-1:0] miss_total_q;

	assign is_get    = (cmd_q == CMD_GET);
	assign is_put    = (cmd_q == CMD_PUT);
	assign is_delete = (cmd_q == CMD_DELETE);

	// Capacity saturated at the table depth, and the count kept by a trim.
	assign cap_wide = (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
	                                                         : CMP_W'(capacity_q);
	assign cap_sat  = OCC_W'(cap_wide);
	assign keep     = (cap_sat == '0) ? '0 : cap_sat - OCC_W'(1);

	// Parallel key compare against every valid entry.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_d[i] = valid_q[i] && (entry_key_q[i] == key_q);
		end
	end

	// Keys are unique, so the match vector is one-hot or empty.
	always_comb begin
		sel_idx  = '0;
		sel_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) begin
				sel_idx  = sel_idx | IDX_W'(i);
				sel_rank = sel_rank | rank_q[i];
			end
		end
	end

	// Lowest free entry for an insert.
	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Valid, rank and occupancy updates for promote, remove, trim and insert.
	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		occ_d   = occ_q;
		if (cmd.apply && found_q) begin
			if (is_get || is_put) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] < sel_rank)) begin
						rank_d[i] = rank_q[i] + IDX_W'(1);
					end
				end
				rank_d[sel_idx] = '0;
			end else if (is_delete) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] > sel_rank)) begin
						rank_d[i] = rank_q[i] - IDX_W'(1);
					end
				end
				valid_d[sel_idx] = 1'b0;
				rank_d[sel_idx]  = '0;
				occ_d            = occ_q - OCC_W'(1);
			end
		end else if (cmd.apply && is_put && (occ_q >= cap_sat)) begin
			// Evict every entry ranked at or beyond the kept count at once.
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && (OCC_W'(rank_q[i]) >= keep)) begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end
			end
			occ_d = keep;
		end else if (cmd.insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + IDX_W'(1);
				end
			end
			valid_d[free_idx] = 1'b1;
			rank_d[free_idx]  = '0;
			occ_d             = occ_q + OCC_W'(1);
		end
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			capacity_q  <= CAPACITY_RESET;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			rank_q  <= rank_d;
			if (cfg_write_en) begin
				capacity_q <= cfg_write_data;
			end
			if (cmd.apply && is_get) begin
				if (found_q) begin
					hits_q <= hits_q + COUNT_BITS'(1);
				end else begin
					misses_q <= misses_q + COUNT_BITS'(1);
				end
			end
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q   <= command;
			key_q   <= key[KEY_BITS-1:0];
			value_q <= value[VALUE_BITS-1:0];
		end
		if (cmd.search) begin
			match_q <= match_d;
			found_q <= |match_d;
		end
		if (cmd.insert) begin
			entry_key_q[free_idx] <= key_q;
		end
		if (cmd.respond) begin
			hit_q        <= found_q && (is_get || is_put || is_delete);
			read_value_q <= (is_get && found_q) ? WORD_BITS'(ram_rdata) : '0;
			hit_total_q  <= hits_q;
			miss_total_q <= misses_q;
		end
	end

	// Value store port control.
	assign ram_we    = (cmd.apply && is_put && found_q) || cmd.insert;
	assign ram_waddr = cmd.insert ? free_idx : sel_idx;
	assign ram_re    = cmd.apply && is_get && found_q;

	lkv_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (sel_idx),
		.rdata (ram_rdata)
	);

	// Status back to the controller.
	assign status.need_insert = is_put && !found_q && (cap_sat != '0);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign hit_total  = hit_total_q;
	assign miss_total = miss_total_q;

endmodule

[src/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Each input beat is a get, put or delete; each produces exactly one result
// beat with the hit flag, the value read by a get hit and the running get hit
// and miss counts. A sequencer takes one item at a time: capture, a parallel
// key compare over all entries, an update step, and a respond step that
// loads the result register. A put of a new key into a nonzero capacity adds
// an insert step after the update step, which evicts first if the table is at
// capacity. The result register holds one finished beat. The next item is
// accepted in the cycle after the result is loaded, and the respond step
// waits only while an earlier result is still unread. Values live in a RAM
// with a registered read; keys, valid bits and recency ranks live in
// flip-flops, so no clearing pass is needed. The capacity register may be
// written only while the block is idle.
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [lkv_pkg::CAP_BITS-1:0]   cfg_write_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lkv_pkg::CMD_BITS-1:0]   command,
	input  logic [lkv_pkg::WORD_BITS-1:0]  key,
	input  logic [lkv_pkg::WORD_BITS-1:0]  value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [lkv_pkg::WORD_BITS-1:0]  read_value,
	output logic [lkv_pkg::COUNT_BITS-1:0] hit_total,
	output logic [lkv_pkg::COUNT_BITS-1:0] miss_total
);

	import lkv_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// Sequencer.
	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// Entry table, value store and result register.
	lkv_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.status         (dp_status),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.command        (command),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.read_value     (read_value),
		.hit_total      (hit_total),
		.miss_total     (miss_total)
	);

endmodule

[src/lkv_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           hit,
	input logic [lkv_pkg::WORD_BITS-1:0]  read_value
);

	// A stalled result beat keeps its value.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_value))

	// A nonzero read value only comes with a hit.
	`ASSERT_SAME(a_value_needs_hit, clk, arst_n, out_valid && (read_value != '0), hit)

	// The block is busy in the cycle after it takes an item.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A result never appears right after its item is taken.
	`ASSERT_SAME(a_no_instant_result, clk, arst_n, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
